// File: hdl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg - shared types and constants for the proportional span allocator
// Widths, register indexes and sequencer states used by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

	localparam int MAX_CHUNKS = 32;
	localparam int IDX_W      = $clog2(MAX_CHUNKS);
	localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);

	localparam int LEN_W  = 10;
	localparam int TIME_W = 32;
	localparam int CFG_W  = 16;
	localparam int SUM_W  = 16;
	localparam int DUR_W  = 33;
	localparam int ACC_W  = 34;
	localparam int PROD_W = TIME_W + LEN_W;
	localparam int DVD_W  = PROD_W + 2;
	localparam int DVS_W  = 32;

	localparam int IN_W        = LEN_W + 2 * TIME_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = 2 * TIME_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DUR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP     = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_TOTAL,
		S_DIV3,
		S_GSTART,
		S_DIVG,
		S_AL_RD,
		S_AL_MUL,
		S_AL_DIV,
		S_AL_WAIT,
		S_LF_RD,
		S_LF_CHK,
		S_LF_SCAN,
		S_LF_DRAIN,
		S_LF_DEC,
		S_LF_W1,
		S_LF_W2,
		S_LF_NEXT,
		S_EM_RD,
		S_EM_SET,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

// File: hdl/psa_div.sv
// ----------------------------------------------------------------------------
// psa_div - shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [psa_pkg::DVD_W-1:0]   dividend,
	input  wire logic [psa_pkg::DVS_W-1:0]   divisor,
	output logic                             done,
	output logic [psa_pkg::DVD_W-1:0]        quotient
);

	localparam int STEP_W = $clog2(psa_pkg::DVD_W + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [psa_pkg::DVD_W-1:0]   quo_q;
	logic [psa_pkg::DVS_W:0]     rem_q;
	logic [psa_pkg::DVS_W-1:0]   dvs_q;
	logic [psa_pkg::DVS_W:0]     rem_sh;
	logic [psa_pkg::DVS_W+1:0]   diff;

	assign rem_sh = {rem_q[psa_pkg::DVS_W-1:0], quo_q[psa_pkg::DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(psa_pkg::DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[psa_pkg::DVS_W+1]) begin
				rem_q <= diff[psa_pkg::DVS_W:0];
				quo_q <= {quo_q[psa_pkg::DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[psa_pkg::DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: hdl/proportional_span_allocator.sv
// ----------------------------------------------------------------------------
// proportional_span_allocator - split a time window into spans by chunk length
// Collects chunk lengths, then divides, lifts short spans and emits the spans.
// ----------------------------------------------------------------------------
// A group's chunk requests are taken one per cycle while idle. The request with
// tlast closes the group; from then on the block is busy until the final span
// has been taken. The busy time for n chunks covers setup (the third of the
// window by reciprocal multiply, then one division for the gap split), then
// the proportional split (one serial division per chunk, the last chunk
// taking the remainder), then up to n passes of n checks: a span at or above
// the minimum is passed over, a short one runs a donor scan over the duration
// memory and a write of both spans when the donor gives time. Then each span
// is emitted, with any output stall. The shared bit-serial divider and the
// duration memory set this pacing. A single chunk or an overflowed group
// produces its one result right after the closing request.
`default_nettype none

module proportional_span_allocator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// chunk_len, window_start_ms, window_end_ms (low bits first), zero filled
	input  wire logic [psa_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  wire logic                               s_tlast,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// span_start_ms, span_end_ms (low bits first)
	output logic [psa_pkg::OUT_TDATA_W-1:0]         m_tdata,
	// overflow
	output logic                                    m_tuser,
	output logic                                    m_tlast,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [psa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [psa_pkg::CFG_W-1:0]          cfg_data
);

	localparam int IW = psa_pkg::IDX_W;
	localparam int CW = psa_pkg::CNT_W;
	localparam int TW = psa_pkg::TIME_W;

	psa_pkg::state_t state_q, state_d;

	logic [psa_pkg::CFG_W-1:0]  min_dur_q, gap_q;
	logic [CW-1:0]              cnt_q;
	logic [psa_pkg::SUM_W-1:0]  sum_q;
	logic                       ovf_q;
	logic [TW-1:0]              t0_q, t1_q;
	logic [TW-1:0]              total_q, graw_q, gtot_q, speak_q, per_gap_q, cur_q;
	logic [IW-1:0]              i_q, k_q, k_s1, pass_q, donor_q;
	logic                       v_s1, dval_q, changed_q;
	logic [psa_pkg::PROD_W-1:0] prod_q;
	logic [psa_pkg::ACC_W-1:0]  alloc_q;
	logic signed [psa_pkg::ACC_W-1:0] dur_i_q, need_q, best_q;
	logic [TW-1:0]              o_start_q, o_end_q;
	logic                       o_ovf_q, o_last_q;

	logic [psa_pkg::LEN_W-1:0]  len_mem [psa_pkg::MAX_CHUNKS];
	logic [psa_pkg::DUR_W-1:0]  dur_mem [psa_pkg::MAX_CHUNKS];
	logic [psa_pkg::LEN_W-1:0]  len_rd_q;
	logic [psa_pkg::DUR_W-1:0]  dur_rd_q;

	// input fields
	logic [psa_pkg::LEN_W-1:0]  in_len, in_len_fix;
	logic [TW-1:0]              in_t0, in_t1;
	logic                       in_acc, out_acc;
	logic                       cnt_full, ovf_next;
	logic [IW-1:0]              last_idx;
	logic [TW-1:0]              total_c;
	logic [2*TW-1:0]            third_prod;
	logic [TW-1:0]              third;

	// control and datapath selects
	logic                       div_start, div_done;
	logic [psa_pkg::DVD_W-1:0]  div_dividend, div_quo;
	logic [psa_pkg::DVS_W-1:0]  div_divisor;
	logic                       dur_we;
	logic [IW-1:0]              dur_waddr, rd_addr;
	logic [psa_pkg::DUR_W-1:0]  dur_wdata;

	logic signed [psa_pkg::ACC_W-1:0] dur_rd_x, mind_x, best_left;

	assign in_len     = s_tdata[psa_pkg::LEN_W-1:0];
	assign in_t0      = s_tdata[psa_pkg::LEN_W +: TW];
	assign in_t1      = s_tdata[psa_pkg::LEN_W + TW +: TW];
	assign in_len_fix = (in_len == '0) ? psa_pkg::LEN_W'(1) : in_len;
	assign in_acc     = s_tvalid && s_tready;
	assign out_acc    = m_tvalid && m_tready;
	assign cnt_full   = (cnt_q == CW'(psa_pkg::MAX_CHUNKS));
	assign ovf_next   = ovf_q || cnt_full;
	assign last_idx   = IW'(cnt_q - CW'(1));
	assign total_c    = (t1_q > t0_q) ? (t1_q - t0_q) : TW'(1);

	// total / 3 by reciprocal multiply, exact over the full 32-bit range
	assign third_prod = (2*TW)'(total_q) * (2*TW)'(32'hAAAA_AAAB);
	assign third      = {1'b0, third_prod[2*TW-1:TW+1]};

	assign dur_rd_x  = signed'({dur_rd_q[psa_pkg::DUR_W-1], dur_rd_q});
	assign mind_x    = signed'({{(psa_pkg::ACC_W-psa_pkg::CFG_W){1'b0}}, min_dur_q});
	assign best_left = best_q - need_q;

	assign cfg_ready = 1'b1;

	psa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			psa_pkg::S_IDLE: begin
				if (in_acc && s_tlast) begin
					if (ovf_next || cnt_q == '0) state_d = psa_pkg::S_OUT;
					else                         state_d = psa_pkg::S_TOTAL;
				end
			end
			psa_pkg::S_TOTAL:  state_d = psa_pkg::S_DIV3;
			psa_pkg::S_DIV3:   state_d = psa_pkg::S_GSTART;
			psa_pkg::S_GSTART: state_d = psa_pkg::S_DIVG;
			psa_pkg::S_DIVG:   if (div_done) state_d = psa_pkg::S_AL_RD;
			psa_pkg::S_AL_RD:  state_d = psa_pkg::S_AL_MUL;
			psa_pkg::S_AL_MUL: begin
				if (i_q == last_idx) state_d = psa_pkg::S_LF_RD;
				else                 state_d = psa_pkg::S_AL_DIV;
			end
			psa_pkg::S_AL_DIV:  state_d = psa_pkg::S_AL_WAIT;
			psa_pkg::S_AL_WAIT: if (div_done) state_d = psa_pkg::S_AL_RD;
			psa_pkg::S_LF_RD:   state_d = psa_pkg::S_LF_CHK;
			psa_pkg::S_LF_CHK: begin
				if (dur_rd_x >= mind_x) state_d = psa_pkg::S_LF_NEXT;
				else                    state_d = psa_pkg::S_LF_SCAN;
			end
			psa_pkg::S_LF_SCAN:  if (k_q == last_idx) state_d = psa_pkg::S_LF_DRAIN;
			psa_pkg::S_LF_DRAIN: state_d = psa_pkg::S_LF_DEC;
			psa_pkg::S_LF_DEC: begin
				if (dval_q && best_left >= mind_x) state_d = psa_pkg::S_LF_W1;
				else                               state_d = psa_pkg::S_LF_NEXT;
			end
			psa_pkg::S_LF_W1: state_d = psa_pkg::S_LF_W2;
			psa_pkg::S_LF_W2: state_d = psa_pkg::S_LF_NEXT;
			psa_pkg::S_LF_NEXT: begin
				if (i_q == last_idx && (!changed_q || pass_q == last_idx))
					state_d = psa_pkg::S_EM_RD;
				else
					state_d = psa_pkg::S_LF_RD;
			end
			psa_pkg::S_EM_RD:  state_d = psa_pkg::S_EM_SET;
			psa_pkg::S_EM_SET: state_d = psa_pkg::S_OUT;
			psa_pkg::S_OUT: begin
				if (out_acc) begin
					if (o_last_q) state_d = psa_pkg::S_IDLE;
					else          state_d = psa_pkg::S_EM_RD;
				end
			end
			default: state_d = psa_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready     = (state_q == psa_pkg::S_IDLE);
		m_tvalid     = (state_q == psa_pkg::S_OUT);
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		dur_we       = 1'b0;
		dur_waddr    = i_q;
		dur_wdata    = '0;
		rd_addr      = (state_q == psa_pkg::S_LF_SCAN) ? k_q : i_q;
		case (state_q)
			psa_pkg::S_GSTART: begin
				div_start    = 1'b1;
				div_dividend = psa_pkg::DVD_W'(gtot_q);
				div_divisor  = psa_pkg::DVS_W'(cnt_q - CW'(1));
			end
			psa_pkg::S_AL_MUL: begin
				// last span takes whatever the others left over
				if (i_q == last_idx) begin
					dur_we    = 1'b1;
					dur_wdata = psa_pkg::DUR_W'(psa_pkg::ACC_W'(speak_q) - alloc_q);
				end
			end
			psa_pkg::S_AL_DIV: begin
				div_start    = 1'b1;
				div_dividend = psa_pkg::DVD_W'({prod_q, 1'b0}) + psa_pkg::DVD_W'(sum_q);
				div_divisor  = psa_pkg::DVS_W'({sum_q, 1'b0});
			end
			psa_pkg::S_AL_WAIT: begin
				if (div_done) begin
					dur_we    = 1'b1;
					dur_wdata = div_quo[psa_pkg::DUR_W-1:0];
				end
			end
			psa_pkg::S_LF_W1: begin
				dur_we    = 1'b1;
				dur_wdata = psa_pkg::DUR_W'(dur_i_q + need_q);
			end
			psa_pkg::S_LF_W2: begin
				dur_we    = 1'b1;
				dur_waddr = donor_q;
				dur_wdata = psa_pkg::DUR_W'(best_left);
			end
			default: ;
		endcase
	end

	assign m_tdata = psa_pkg::OUT_TDATA_W'({o_end_q, o_start_q});
	assign m_tuser = o_ovf_q;
	assign m_tlast = o_last_q;

	always_ff @(posedge clk) begin
		if (in_acc && !cnt_full)
			len_mem[cnt_q[IW-1:0]] <= in_len_fix;
		len_rd_q <= len_mem[i_q];
		if (dur_we)
			dur_mem[dur_waddr] <= dur_wdata;
		dur_rd_q <= dur_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= psa_pkg::S_IDLE;
			min_dur_q <= '0;
			gap_q     <= '0;
			cnt_q     <= '0;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
			v_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == psa_pkg::S_LF_SCAN);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					psa_pkg::REG_MIN_DUR: min_dur_q <= cfg_data;
					psa_pkg::REG_GAP:     gap_q     <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				if (cnt_full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
					sum_q <= sum_q + psa_pkg::SUM_W'(in_len_fix);
				end
			end
			// close the group once its final span is taken
			if (out_acc && o_last_q) begin
				cnt_q <= '0;
				sum_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (v_s1 && k_s1 != i_q && dur_rd_x > best_q) begin
			best_q  <= dur_rd_x;
			donor_q <= k_s1;
			dval_q  <= 1'b1;
		end
		case (state_q)
			psa_pkg::S_IDLE: begin
				if (in_acc && s_tlast) begin
					t0_q      <= in_t0;
					t1_q      <= in_t1;
					o_ovf_q   <= ovf_next;
					o_last_q  <= 1'b1;
					o_start_q <= ovf_next ? '0 : in_t0;
					o_end_q   <= ovf_next ? '0 : in_t1;
				end
			end
			psa_pkg::S_TOTAL: begin
				total_q <= total_c;
				graw_q  <= TW'(TW'(cnt_q - CW'(1)) * TW'(gap_q));
			end
			psa_pkg::S_DIV3: gtot_q <= (graw_q > third) ? third : graw_q;
			psa_pkg::S_GSTART: speak_q <= total_q - gtot_q;
			psa_pkg::S_DIVG: begin
				if (div_done) begin
					per_gap_q <= div_quo[TW-1:0];
					i_q       <= '0;
					alloc_q   <= '0;
				end
			end
			psa_pkg::S_AL_MUL: begin
				prod_q <= speak_q * len_rd_q;
				if (i_q == last_idx) begin
					i_q       <= '0;
					pass_q    <= '0;
					changed_q <= 1'b0;
				end
			end
			psa_pkg::S_AL_WAIT: begin
				if (div_done) begin
					alloc_q <= alloc_q + psa_pkg::ACC_W'(div_quo[psa_pkg::DUR_W-1:0]);
					i_q     <= i_q + IW'(1);
				end
			end
			psa_pkg::S_LF_CHK: begin
				dur_i_q <= dur_rd_x;
				need_q  <= mind_x - dur_rd_x;
				k_q     <= '0;
				best_q  <= -psa_pkg::ACC_W'(1);
				dval_q  <= 1'b0;
			end
			psa_pkg::S_LF_SCAN: begin
				if (k_q != last_idx)
					k_q <= k_q + IW'(1);
			end
			psa_pkg::S_LF_W2: changed_q <= 1'b1;
			psa_pkg::S_LF_NEXT: begin
				if (i_q == last_idx) begin
					i_q <= '0;
					if (!changed_q || pass_q == last_idx) begin
						cur_q <= t0_q;
					end else begin
						pass_q    <= pass_q + IW'(1);
						changed_q <= 1'b0;
					end
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
			psa_pkg::S_EM_SET: begin
				o_start_q <= cur_q;
				o_end_q   <= (i_q == last_idx) ? t1_q : cur_q + dur_rd_q[TW-1:0];
				o_ovf_q   <= 1'b0;
				o_last_q  <= (i_q == last_idx);
			end
			psa_pkg::S_OUT: begin
				if (out_acc && !o_last_q) begin
					cur_q <= o_end_q + per_gap_q;
					i_q   <= i_q + IW'(1);
				end
			end
			default: ;
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides active together");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == psa_pkg::S_DIVG || state_q == psa_pkg::S_AL_WAIT))
		else $error("divider result arrived outside a wait state");

	a_group_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> (cnt_q == '0 && sum_q == '0 && !ovf_q))
		else $error("group state not cleared after final span");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("overflow result not marked last");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for proportional_span_allocator
// Streams groups of chunk lengths with random windows, predicts every span
// (proportional split, capped gaps, rounding drift, short-span lifting,
// overflow) and compares each accepted span with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int  LIMIT_CYCLES = 3_000_000;
	localparam int  MAX_REPORTS  = 10;

	typedef struct {
		logic [psa_pkg::TIME_W-1:0] start_ms;
		logic [psa_pkg::TIME_W-1:0] end_ms;
		logic                       ovf;
		logic                       last;
	} span_t;

	logic                               clk;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [psa_pkg::IN_TDATA_W-1:0]     s_tdata;
	logic                               s_tlast;
	logic                               m_tvalid;
	logic                               m_tready;
	logic [psa_pkg::OUT_TDATA_W-1:0]    m_tdata;
	logic                               m_tuser;
	logic                               m_tlast;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [psa_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [psa_pkg::CFG_W-1:0]          cfg_data;

	proportional_span_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	int unsigned      min_dur;
	int unsigned      gap;
	int unsigned      grp_lens[$];
	bit               grp_ovf;
	span_t            span_q[$];

	int               errors;
	int               mismatches;
	int               send_idle_pct;
	int               recv_stall_pct;
	int               hold_cnt;
	longint           cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor
	function automatic void lift_spans(ref longint dur[psa_pkg::MAX_CHUNKS], input int n);
		longint need;
		longint best;
		int     donor;
		bit     changed;
		for (int pass = 0; pass < n; pass++) begin
			changed = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (dur[i] >= longint'(min_dur))
					continue;
				need  = longint'(min_dur) - dur[i];
				donor = -1;
				best  = -1;
				for (int k = 0; k < n; k++) begin
					if (k != i && dur[k] > best) begin
						best  = dur[k];
						donor = k;
					end
				end
				if (donor >= 0 && dur[donor] - need >= longint'(min_dur)) begin
					dur[i]     += need;
					dur[donor] -= need;
					changed = 1'b1;
				end
			end
			if (!changed)
				break;
		end
	endfunction

	function automatic void close_group(logic [psa_pkg::TIME_W-1:0] t0,
			logic [psa_pkg::TIME_W-1:0] t1);
		longint          dur[psa_pkg::MAX_CHUNKS];
		longint          total;
		longint          gap_total;
		longint          per_gap;
		longint          speak;
		longint          alloc;
		longint unsigned sum;
		longint unsigned num;
		logic [psa_pkg::TIME_W-1:0] cur;
		span_t           sp;
		int              n;
		n   = grp_lens.size();
		sum = 0;
		foreach (grp_lens[i])
			sum += grp_lens[i];
		if (grp_ovf || n == 1) begin
			sp.start_ms = grp_ovf ? '0 : t0;
			sp.end_ms   = grp_ovf ? '0 : t1;
			sp.ovf      = grp_ovf;
			sp.last     = 1'b1;
			span_q      = {span_q, sp};
		end else begin
			total     = (t1 > t0) ? longint'(t1) - longint'(t0) : 1;
			gap_total = longint'(n - 1) * longint'(gap);
			if (gap_total > total / 3)
				gap_total = total / 3;
			per_gap = gap_total / (n - 1);
			speak   = total - gap_total;
			alloc   = 0;
			for (int i = 0; i < n; i++) begin
				num    = 2 * longint'(speak) * grp_lens[i] + sum;
				dur[i] = longint'(num / (2 * sum));
				alloc += dur[i];
			end
			dur[n-1] += speak - alloc;
			lift_spans(dur, n);
			cur = t0;
			for (int i = 0; i < n; i++) begin
				sp.start_ms = cur;
				sp.end_ms   = (i == n - 1) ? t1 : cur + dur[i][psa_pkg::TIME_W-1:0];
				sp.ovf      = 1'b0;
				sp.last     = (i == n - 1);
				span_q      = {span_q, sp};
				cur = sp.end_ms + per_gap[psa_pkg::TIME_W-1:0];
			end
		end
		grp_lens.delete();
		grp_ovf = 1'b0;
	endfunction

	function automatic void take_chunk(logic [psa_pkg::LEN_W-1:0] len,
			logic [psa_pkg::TIME_W-1:0] t0, logic [psa_pkg::TIME_W-1:0] t1, bit is_last);
		int unsigned l;
		l = (len == '0) ? 1 : len;
		if (grp_lens.size() < psa_pkg::MAX_CHUNKS)
			grp_lens = {grp_lens, l};
		else
			grp_ovf = 1'b1;
		if (is_last)
			close_group(t0, t1);
	endfunction

	// ---------------------------------------------------------------- drivers
	task automatic send_chunk(logic [psa_pkg::LEN_W-1:0] len,
			logic [psa_pkg::TIME_W-1:0] t0, logic [psa_pkg::TIME_W-1:0] t1, bit is_last);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {{(psa_pkg::IN_TDATA_W - psa_pkg::IN_W){1'b0}}, t1, t0, len};
		s_tlast  = is_last;
		do @(posedge clk); while (!s_tready);
		take_chunk(len, t0, t1, is_last);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(logic [psa_pkg::CFG_IDX_W-1:0] idx,
			logic [psa_pkg::CFG_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == psa_pkg::REG_MIN_DUR)
			min_dur = val;
		else
			gap = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// let every pending span drain so the block is idle
	task automatic drain();
		while (span_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic send_group(int n, logic [psa_pkg::TIME_W-1:0] t0,
			logic [psa_pkg::TIME_W-1:0] t1);
		for (int i = 0; i < n; i++)
			send_chunk(psa_pkg::LEN_W'($urandom_range(0, 1023)), $urandom, $urandom, 1'b0);
		send_chunk(psa_pkg::LEN_W'($urandom_range(0, 1023)), t0, t1, 1'b1);
	endtask

	task automatic random_group();
		int unsigned pick;
		int unsigned n;
		logic [psa_pkg::TIME_W-1:0] t0;
		logic [psa_pkg::TIME_W-1:0] t1;
		pick = $urandom_range(99);
		n = (pick < 85) ? $urandom_range(1, 6) :
			(pick < 96) ? $urandom_range(7, psa_pkg::MAX_CHUNKS) :
			$urandom_range(psa_pkg::MAX_CHUNKS + 1, 36);
		pick = $urandom_range(99);
		t0 = $urandom;
		if (pick < 70)
			t1 = t0 + $urandom_range(0, 200000);
		else if (pick < 80)
			t1 = t0 + $urandom_range(0, 40);
		else
			t1 = $urandom;
		send_group(n - 1, t0, t1);
	endtask

	// ---------------------------------------------------------------- receiver
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				m_tready = 1'b0;
				hold_cnt--;
			end else begin
				m_tready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		span_t exp_span;
		if (arst_n && m_tvalid && m_tready) begin
			if (span_q.size() == 0) begin
				errors++;
				if (mismatches++ < MAX_REPORTS)
					$display("unexpected span: start %h end %h ovf %b last %b",
						m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast);
			end else begin
				exp_span = span_q.pop_front();
				if (m_tdata[31:0] !== exp_span.start_ms || m_tdata[63:32] !== exp_span.end_ms ||
						m_tuser !== exp_span.ovf || m_tlast !== exp_span.last) begin
					errors++;
					if (mismatches++ < MAX_REPORTS)
						$display("span mismatch: exp %h %h %b %b got %h %h %b %b",
							exp_span.start_ms, exp_span.end_ms, exp_span.ovf, exp_span.last,
							m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast);
				end
			end
		end
	end

	// ---------------------------------------------------------------- tests
	task automatic test_directed();
		// single chunk covers the whole window
		send_chunk(10'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		send_chunk(10'h3FF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		// two chunks, extreme lengths
		send_chunk(10'h3FF, '0, '0, 1'b0);
		send_chunk(10'd0, 32'd1000, 32'd51000, 1'b1);
		// reversed and empty windows
		send_chunk(10'd5, '0, '0, 1'b0);
		send_chunk(10'd7, 32'hFFFF_FF00, 32'h0000_0010, 1'b1);
		send_chunk(10'd5, '0, '0, 1'b0);
		send_chunk(10'd7, 32'd500, 32'd500, 1'b1);
		// rounding drift drives the last duration negative
		repeat (3) send_chunk(10'd1, '0, '0, 1'b0);
		send_chunk(10'd1, 32'd100, 32'd102, 1'b1);
		drain();
		write_reg(psa_pkg::REG_MIN_DUR, 16'd300);
		write_reg(psa_pkg::REG_GAP, 16'd65535);
		// short span is lifted from the large one; gap capped at a third
		send_chunk(10'd1, '0, '0, 1'b0);
		send_chunk(10'd1000, 32'd0, 32'd3000, 1'b1);
		drain();
		write_reg(psa_pkg::REG_GAP, 16'd0);
		write_reg(psa_pkg::REG_MIN_DUR, 16'd0);
		// group too long
		send_group(psa_pkg::MAX_CHUNKS, 32'd0, 32'd100000);
		drain();
	endtask

	task automatic test_config_sweep();
		logic [psa_pkg::CFG_W-1:0] mins[4] = '{16'd0, 16'd65535, 16'd2000, 16'd0};
		logic [psa_pkg::CFG_W-1:0] gaps[4] = '{16'd65535, 16'd0, 16'd150, 16'd1};
		for (int p = 0; p < 4; p++) begin
			write_reg(psa_pkg::REG_MIN_DUR, mins[p]);
			write_reg(psa_pkg::REG_GAP, gaps[p]);
			repeat (3) random_group();
			drain();
		end
	endtask

	task automatic test_idling();
		int sp[4] = '{0, 80, 0, 7};
		int rp[4] = '{0, 0, 80, 7};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = sp[p];
			recv_stall_pct = rp[p];
			write_reg(psa_pkg::REG_MIN_DUR, psa_pkg::CFG_W'($urandom_range(0, 3000)));
			write_reg(psa_pkg::REG_GAP, psa_pkg::CFG_W'($urandom_range(0, 500)));
			repeat (5) random_group();
			drain();
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_cnt = 3000;
		repeat (8) send_group(2, 32'd0, 32'd60000);
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = psa_pkg::REG_MIN_DUR;
		cfg_data  = '0;
		min_dur   = 0;
		gap       = 0;
		grp_ovf   = 1'b0;
		errors    = 0;
		mismatches = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cnt  = 0;
		cycles    = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_directed();
		test_config_sweep();
		test_idling();
		test_backpressure();

		while (span_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire
